// ----- sv/cfl_pkg.sv -----
package cfl_pkg;

    localparam int LINE_W          = 24;
    localparam int LINE_BITS_DEF   = 24;
    localparam int QUEUE_DEPTH_DEF = 4;

    // token kinds
    localparam logic [3:0] K_WORD   = 4'd0;
    localparam logic [3:0] K_COMMA  = 4'd1;
    localparam logic [3:0] K_ASSIGN = 4'd2;
    localparam logic [3:0] K_SEMI   = 4'd3;
    localparam logic [3:0] K_LINE   = 4'd4;
    localparam logic [3:0] K_OPEN   = 4'd5;
    localparam logic [3:0] K_CLOSE  = 4'd6;
    localparam logic [3:0] K_LINK   = 4'd7;
    localparam logic [3:0] K_END    = 4'd8;
    localparam logic [3:0] K_ERROR  = 4'd9;

    // character codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQ     = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQ     = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic       has;
        logic [7:0] data;
        logic       tend;
        logic [3:0] kind;
    } t_res;

    // one queue entry holds every result of one input transaction
    typedef struct packed {
        logic              two;
        t_res [1:0]        res;
        logic [LINE_W-1:0] line;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

    function automatic t_res mk_res(input logic has, input logic [7:0] data,
                                    input logic tend, input logic [3:0] kind);
        t_res r;
        r.has  = has;
        r.data = has ? data : 8'd0;
        r.tend = tend;
        r.kind = kind;
        return r;
    endfunction

endpackage

// ----- sv/cfl_front.sv -----
module cfl_front #(
    parameter int LINE_BITS = cfl_pkg::LINE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic            i_func,
    input  logic [7:0]      i_char_byte,
    output logic            o_push,
    output cfl_pkg::t_entry o_entry
);
    import cfl_pkg::*;

    typedef enum logic [6:0] {
        M_NORMAL   = 7'b0000001,
        M_LINECMT  = 7'b0000010,
        M_LINETAIL = 7'b0000100,
        M_BLOCK0   = 7'b0001000,
        M_BLOCK    = 7'b0010000,
        M_STRING   = 7'b0100000,
        M_LINK     = 7'b1000000
    } t_mode;

    t_mode                r_mode, n_mode;
    logic [7:0]           r_hbyte, n_hbyte;
    logic                 r_held, n_held;
    logic                 r_tok, n_tok;
    logic                 r_keep, n_keep;
    logic                 r_skip, n_skip;
    logic [LINE_BITS-1:0] r_line, n_line;

    t_res [1:0]           res;
    logic [1:0]           cnt;
    logic                 do_norm;
    logic                 buf_w;
    logic [7:0]           c;

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [3:0] spec_kind(input logic [7:0] ch);
        logic [3:0] k;
        case (ch)
            CH_COMMA:  k = K_COMMA;
            CH_EQ:     k = K_ASSIGN;
            CH_SEMI:   k = K_SEMI;
            CH_LF:     k = K_LINE;
            CH_LBRACE: k = K_OPEN;
            CH_RBRACE: k = K_CLOSE;
            default:   k = K_WORD;
        endcase
        return k;
    endfunction

    assign c = i_char_byte;

    always_comb begin
        n_mode  = r_mode;
        n_hbyte = r_hbyte;
        n_held  = r_held;
        n_tok   = r_tok;
        n_keep  = r_keep;
        n_skip  = r_skip;
        n_line  = r_line;
        res     = '0;
        cnt     = 2'd0;
        do_norm = 1'b0;
        buf_w   = 1'b0;
        if (i_func) begin
            if (r_mode inside {M_STRING, M_LINK, M_BLOCK0, M_BLOCK}) begin
                res[0] = mk_res(1'b0, 8'd0, 1'b1, K_ERROR);
                cnt    = 2'd1;
            end else begin
                if (r_tok || r_held) begin
                    res[0] = mk_res(r_held, r_hbyte, 1'b1, K_WORD);
                    cnt    = 2'd1;
                end
                res[cnt[0]] = mk_res(1'b0, 8'd0, 1'b1, K_END);
                cnt         = cnt + 2'd1;
            end
            n_mode  = M_NORMAL;
            n_hbyte = 8'd0;
            n_held  = 1'b0;
            n_tok   = 1'b0;
            n_keep  = 1'b0;
            n_skip  = 1'b0;
            n_line  = LINE_BITS'(1);
        end else begin
            case (r_mode)
                M_LINECMT: begin
                    if (c inside {CH_LF, CH_CR}) begin
                        if (c == CH_LF) n_line = line_inc(n_line);
                        n_mode = M_LINETAIL;
                    end
                end
                M_LINETAIL: begin
                    if (c inside {CH_LF, CH_CR}) begin
                        if (c == CH_LF) n_line = line_inc(n_line);
                    end else begin
                        // comment over: a pending word closes here
                        if (n_tok || n_held) begin
                            res[cnt[0]] = mk_res(n_held, n_hbyte, 1'b1, K_WORD);
                            cnt         = cnt + 2'd1;
                            n_held      = 1'b0;
                            n_hbyte     = 8'd0;
                            n_tok       = 1'b0;
                        end
                        n_mode  = M_NORMAL;
                        do_norm = 1'b1;
                    end
                end
                M_BLOCK0, M_BLOCK: begin
                    if (c == CH_LF) n_line = line_inc(n_line);
                    if (r_mode == M_BLOCK && r_hbyte == CH_STAR && c == CH_SLASH) begin
                        n_hbyte = 8'd0;
                        n_mode  = M_NORMAL;
                        n_skip  = 1'b1;
                    end else begin
                        n_hbyte = c;
                        n_mode  = M_BLOCK;
                    end
                end
                M_STRING: begin
                    if (c inside {CH_DQ, CH_SQ}) begin
                        if (r_keep) begin
                            res[0] = mk_res(1'b1, c, 1'b1, K_WORD);
                            cnt    = 2'd1;
                        end else if (r_tok) begin
                            res[0] = mk_res(1'b0, 8'd0, 1'b1, K_WORD);
                            cnt    = 2'd1;
                        end
                        n_mode  = M_NORMAL;
                        n_hbyte = 8'd0;
                        n_held  = 1'b0;
                        n_tok   = 1'b0;
                        n_keep  = 1'b0;
                        n_skip  = 1'b0;
                    end else begin
                        res[0] = mk_res(1'b1, c, 1'b0, K_WORD);
                        cnt    = 2'd1;
                        n_tok  = 1'b1;
                    end
                end
                M_LINK: begin
                    if (c == CH_RBRACK) begin
                        res[0]  = mk_res(1'b0, 8'd0, 1'b1, K_LINK);
                        cnt     = 2'd1;
                        n_mode  = M_NORMAL;
                        n_hbyte = 8'd0;
                        n_held  = 1'b0;
                        n_tok   = 1'b0;
                        n_keep  = 1'b0;
                        n_skip  = 1'b0;
                    end else begin
                        res[0] = mk_res(1'b1, c, 1'b0, K_WORD);
                        cnt    = 2'd1;
                    end
                end
                default: begin
                    n_mode  = M_NORMAL;
                    do_norm = 1'b1;
                end
            endcase

            if (do_norm) begin
                buf_w = n_tok || n_held;
                if (c inside {CH_SPACE, CH_TAB, CH_CR}) begin
                    if (buf_w && !n_skip) begin
                        res[cnt[0]] = mk_res(n_held, n_hbyte, 1'b1, K_WORD);
                        cnt         = cnt + 2'd1;
                        n_held      = 1'b0;
                        n_hbyte     = 8'd0;
                        n_tok       = 1'b0;
                    end
                end else begin
                    n_skip = 1'b0;
                    if (c inside {CH_HASH, CH_BAR}) begin
                        n_mode = M_LINECMT;
                    end else if (n_held && n_hbyte == CH_SLASH &&
                                 (c inside {CH_SLASH, CH_STAR})) begin
                        // held slash opens a comment instead of ending the word
                        n_held  = 1'b0;
                        n_hbyte = 8'd0;
                        n_mode  = (c == CH_SLASH) ? M_LINECMT : M_BLOCK0;
                    end else if (c inside {CH_COMMA, CH_EQ, CH_SEMI, CH_LF,
                                           CH_LBRACE, CH_RBRACE}) begin
                        if (c == CH_LF) n_line = line_inc(n_line);
                        if (buf_w) begin
                            res[cnt[0]] = mk_res(n_held, n_hbyte, 1'b1, K_WORD);
                            cnt         = cnt + 2'd1;
                            n_held      = 1'b0;
                            n_hbyte     = 8'd0;
                            n_tok       = 1'b0;
                        end
                        res[cnt[0]] = mk_res(1'b1, c, 1'b1, spec_kind(c));
                        cnt         = cnt + 2'd1;
                    end else if (c == CH_LBRACK) begin
                        if (n_held) begin
                            res[cnt[0]] = mk_res(1'b1, n_hbyte, 1'b0, K_WORD);
                            cnt         = cnt + 2'd1;
                        end
                        n_held  = 1'b0;
                        n_hbyte = 8'd0;
                        n_tok   = 1'b0;
                        n_mode  = M_LINK;
                    end else if (c inside {CH_DQ, CH_SQ}) begin
                        if (buf_w) begin
                            if (n_held) begin
                                res[cnt[0]] = mk_res(1'b1, n_hbyte, 1'b0, K_WORD);
                                cnt         = cnt + 2'd1;
                            end
                            n_held      = 1'b0;
                            n_hbyte     = 8'd0;
                            res[cnt[0]] = mk_res(1'b1, c, 1'b0, K_WORD);
                            cnt         = cnt + 2'd1;
                            n_keep      = 1'b1;
                            n_tok       = 1'b1;
                        end else begin
                            n_keep = 1'b0;
                            n_tok  = 1'b0;
                        end
                        n_mode = M_STRING;
                    end else begin
                        if (n_held) begin
                            res[cnt[0]] = mk_res(1'b1, n_hbyte, 1'b0, K_WORD);
                            cnt         = cnt + 2'd1;
                            n_tok       = 1'b1;
                        end
                        n_hbyte = c;
                        n_held  = 1'b1;
                    end
                end
            end
        end
    end

    assign o_push        = i_accept && (cnt != 2'd0);
    assign o_entry.two   = cnt[1];
    assign o_entry.res   = res;
    // all results of a transaction carry the count after its own increments
    assign o_entry.line  = LINE_W'(i_func ? r_line : n_line);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_NORMAL;
            r_hbyte <= 8'd0;
            r_held  <= 1'b0;
            r_tok   <= 1'b0;
            r_keep  <= 1'b0;
            r_skip  <= 1'b0;
            r_line  <= LINE_BITS'(1);
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_hbyte <= n_hbyte;
            r_held  <= n_held;
            r_tok   <= n_tok;
            r_keep  <= n_keep;
            r_skip  <= n_skip;
            r_line  <= n_line;
        end
    end

endmodule

// ----- sv/cfl_queue.sv -----
module cfl_queue #(
    parameter int DEPTH = cfl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfl_pkg::t_entry i_entry,
    input  logic            i_pop,
    output cfl_pkg::t_entry o_head,
    output cfl_pkg::t_qstat o_stat
);
    import cfl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_slot [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_stat.empty = (r_count == CW'(0));
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_slot[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) n_wptr = (r_wptr == AW'(DEPTH - 1)) ? AW'(0) : r_wptr + 1'b1;
        if (do_pop)  n_rptr = (r_rptr == AW'(DEPTH - 1)) ? AW'(0) : r_rptr + 1'b1;
        if (do_push && !do_pop)      n_count = r_count + 1'b1;
        else if (do_pop && !do_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_slot[r_wptr] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ----- sv/cfl_back.sv -----
module cfl_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cfl_pkg::t_entry              i_head,
    input  cfl_pkg::t_qstat              i_qstat,
    input  logic                         i_stall,
    output logic                         o_pop,
    output logic                         o_valid,
    output logic [7:0]                   o_text_byte,
    output logic                         o_has_byte,
    output logic                         o_token_end,
    output logic [3:0]                   o_kind,
    output logic [cfl_pkg::LINE_W-1:0]   o_line_number,
    output logic                         o_last_of_item
);
    import cfl_pkg::*;

    logic r_sub, n_sub;
    logic take;
    t_res cur;

    assign cur            = i_head.res[r_sub];
    assign o_valid        = !i_qstat.empty;
    assign o_text_byte    = cur.data;
    assign o_has_byte     = cur.has;
    assign o_token_end    = cur.tend;
    assign o_kind         = cur.kind;
    assign o_line_number  = i_head.line;
    assign o_last_of_item = r_sub || !i_head.two;

    assign take  = o_valid && !i_stall;
    assign o_pop = take && o_last_of_item;

    always_comb begin
        n_sub = r_sub;
        if (take) n_sub = !o_last_of_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else begin
            r_sub <= n_sub;
        end
    end

endmodule

// ----- sv/config_text_lexer.sv -----
// Each result is written into the registered result queue and is shown from its head.
// Throughput: one input byte per cycle while the result queue has room; results
// leave at one per cycle while i_stall is low, so the two results of one byte leave in turn.
// The QUEUE_DEPTH-entry result queue between lexer and emitter absorbs output stalls.
// Reset (synchronous, active low): lexer back to normal mode, line count one,
// queue empty. No clearing pass.
module config_text_lexer #(
    parameter int LINE_BITS   = cfl_pkg::LINE_BITS_DEF,
    parameter int QUEUE_DEPTH = cfl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_func,
    input  logic [7:0]                 i_char_byte,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_text_byte,
    output logic                       o_has_byte,
    output logic                       o_token_end,
    output logic [3:0]                 o_kind,
    output logic [cfl_pkg::LINE_W-1:0] o_line_number,
    output logic                       o_last_of_item
);
    import cfl_pkg::*;

    logic   in_accept;
    logic   push;
    logic   pop;
    t_entry entry;
    t_entry head;
    t_qstat qstat;

    assign o_stall   = qstat.full;
    assign in_accept = i_valid && !o_stall;

    cfl_front #(.LINE_BITS(LINE_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_func      (i_func),
        .i_char_byte (i_char_byte),
        .o_push      (push),
        .o_entry     (entry)
    );

    cfl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    cfl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_qstat        (qstat),
        .i_stall        (i_stall),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_text_byte    (o_text_byte),
        .o_has_byte     (o_has_byte),
        .o_token_end    (o_token_end),
        .o_kind         (o_kind),
        .o_line_number  (o_line_number),
        .o_last_of_item (o_last_of_item)
    );

    // a result without a byte always closes a token
    a_bare_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_byte) |-> o_token_end)
        else $error("byte-less result without token end");

    // text inside a token never carries a kind
    a_mid_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_token_end) |-> (o_kind == K_WORD))
        else $error("kind set on a non-closing result");

    // end and error tokens are always the last result of their transaction
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_end && (o_kind == K_END || o_kind == K_ERROR))
        |-> o_last_of_item)
        else $error("end or error token not last of transaction");

    // the second result of a pair follows right behind the first
    a_pair_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_item) |=> (o_valid && o_last_of_item))
        else $error("second result of a transaction missing");

endmodule
